// ===== hw/rtl/substring_occurrence_counter_unit_defines.svh =====
// assertion macros shared by the substring occurrence counter rtl
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef SUBSTRING_OCCURRENCE_COUNTER_UNIT_DEFINES_SVH
`define SUBSTRING_OCCURRENCE_COUNTER_UNIT_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define SOCU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition in one cycle implies a consequence in the next
`define SOCU_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/socu_pkg.sv =====
// types and constants of the substring occurrence counter
// no dependencies
`timescale 1ns / 1ps

package socu_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned LenW       = 5;
  localparam int unsigned OutCountW  = 16;
  localparam int unsigned PatBytes   = 16;
  localparam int unsigned QueueDepth = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPatternLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPatternLen  = 2'd2;

  // classified byte handed from front to back
  typedef struct packed {
    logic hit;
    logic start;
  } mid_word_t;

  // result word
  typedef struct packed {
    logic                 match;
    logic [OutCountW-1:0] count;
    logic                 sat;
  } res_word_t;

endpackage

// ===== hw/rtl/socu_fifo.sv =====
// small synchronous queue used between front and back and at the result side
// depends on socu_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "substring_occurrence_counter_unit_defines.svh"

module socu_fifo import socu_pkg::*; #(
  parameter int unsigned Width = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [Width-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  logic pop_only, push_only;
  assign pop_only  = do_pop && !do_push;
  assign push_only = do_push && !do_pop;

  `SOCU_ASSERT(a_fill_in_range, cnt_q <= CntW'(QueueDepth), "queue fill above depth")
  `SOCU_ASSERT_NEXT(a_pop_drains, pop_only, cnt_q == $past(cnt_q) - 1'b1, "pop lost")
  `SOCU_ASSERT_NEXT(a_push_fills, push_only, cnt_q == $past(cnt_q) + 1'b1, "push lost")

endmodule

// ===== hw/rtl/socu_front.sv =====
// front end: pattern registers, byte history and match detection
// depends on socu_pkg
`timescale 1ns / 1ps

module socu_front import socu_pkg::*; #(
  parameter int unsigned PatternMax = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                accept_i,
  input  logic [ByteW-1:0]    text_byte_i,
  input  logic                start_i,
  output mid_word_t           word_o
);

  localparam int unsigned HistDepth = PatternMax - 1;
  localparam int unsigned HistSlots = (HistDepth > 0) ? HistDepth : 1;
  localparam int unsigned VldW      = $clog2(PatternMax + 1);

  logic [CfgDataW-1:0] pat_low_q, pat_high_q;
  logic [LenW-1:0]     pat_len_q;
  logic [ByteW-1:0]    hist_q [HistSlots];
  logic [VldW-1:0]     vld_q, vld_d, vld_eff;

  logic [ByteW-1:0] pat [PatBytes];
  logic [LenW-1:0]  len_eff, len_m1, idx;
  logic             hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPatternLow:  pat_low_q  <= cfg_data_i;
        CfgPatternHigh: pat_high_q <= cfg_data_i;
        CfgPatternLen:  pat_len_q  <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int b = 0; b < PatBytes / 2; b++) begin
      pat[b]                = pat_low_q[b*ByteW +: ByteW];
      pat[b + PatBytes / 2] = pat_high_q[b*ByteW +: ByteW];
    end
  end

  // start of text drops the history before this byte is compared
  assign vld_eff = start_i ? '0 : vld_q;
  assign len_eff = (pat_len_q > LenW'(PatternMax)) ? LenW'(PatternMax) : pat_len_q;
  assign len_m1  = len_eff - 1'b1;

  // newest byte against the last pattern byte, slot k-1 against byte len-1-k
  always_comb begin
    hit = (len_eff != '0) && (LenW'(vld_eff) >= len_m1) && (pat[len_m1[3:0]] == text_byte_i);
    for (int k = 1; k < PatternMax; k++) begin
      idx = len_m1 - LenW'(k);
      if (LenW'(k) < len_eff && pat[idx[3:0]] != hist_q[k-1]) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    vld_d = vld_eff;
    if (vld_eff < VldW'(HistDepth)) begin
      vld_d = vld_eff + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (accept_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int k = HistSlots - 1; k > 0; k--) begin
        hist_q[k] <= hist_q[k-1];
      end
      hist_q[0] <= text_byte_i;
    end
  end

  assign word_o.hit   = hit;
  assign word_o.start = start_i;

endmodule

// ===== hw/rtl/socu_back.sv =====
// back end: saturating occurrence count and result word assembly
// depends on socu_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "substring_occurrence_counter_unit_defines.svh"

module socu_back import socu_pkg::*; #(
  parameter int unsigned CountBits = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      mid_empty_i,
  input  mid_word_t mid_word_i,
  output logic      mid_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output res_word_t res_word_o
);

  localparam logic [CountBits-1:0] CntMax = {CountBits{1'b1}};

  logic [CountBits-1:0] cnt_q, cnt_d, cnt_base;
  logic [31:0]          cnt_wide;
  logic                 xfer;

  assign xfer       = !mid_empty_i && !res_full_i;
  assign mid_pop_o  = xfer;
  assign res_push_o = xfer;

  always_comb begin
    cnt_base = mid_word_i.start ? '0 : cnt_q;
    cnt_d    = cnt_base;
    if (mid_word_i.hit && cnt_base != CntMax) begin
      cnt_d = cnt_base + 1'b1;
    end
  end

  assign cnt_wide          = 32'(cnt_d);
  assign res_word_o.match  = mid_word_i.hit;
  assign res_word_o.count  = cnt_wide[OutCountW-1:0];
  assign res_word_o.sat    = (cnt_d == CntMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (xfer) begin
      cnt_q <= cnt_d;
    end
  end

  logic step_up, restart;
  assign step_up = xfer && !mid_word_i.start && mid_word_i.hit && cnt_q != CntMax;
  assign restart = xfer && mid_word_i.start;

  `SOCU_ASSERT_NEXT(a_count_steps, step_up, cnt_q == $past(cnt_q) + 1'b1, "count missed a hit")
  `SOCU_ASSERT_NEXT(a_count_holds, !xfer, $stable(cnt_q), "count moved without a word")
  `SOCU_ASSERT_NEXT(a_restart_low, restart, cnt_q <= CountBits'(1), "start did not clear count")

endmodule

// ===== hw/rtl/substring_occurrence_counter_unit.sv =====
// top level of the substring occurrence counter
// depends on socu_pkg, socu_front, socu_fifo and socu_back
`timescale 1ns / 1ps
//
// channel  direction  handshake            word
// -------  ---------  -------------------  -------------------------------------------
// text     in         push_i / full_o      text_byte_i, start_of_text_i
// result   out        pop_i / empty_o      match_ends_here_o, occurrence_count_o,
//                                          count_saturated_o
// config   in         cfg_we_i             cfg_idx_i, cfg_data_i
//
// one text byte per clock sustained while full_o is low; the byte compare against the
// pattern is done in the front in the cycle a byte is taken, the count update in the
// back after the word leaves the front queue, and results then pass the result queue
// both queues are two words deep; a result-side stall raises full_o once both are full
// reset clears config, history fill, count and queues; there is no clearing pass

module substring_occurrence_counter_unit import socu_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // text bytes
  input  logic                 push_i,
  output logic                 full_o,
  input  logic [ByteW-1:0]     text_byte_i,
  input  logic                 start_of_text_i,
  // results
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic                 match_ends_here_o,
  output logic [OutCountW-1:0] occurrence_count_o,
  output logic                 count_saturated_o
);

  mid_word_t front_word, mid_word;
  res_word_t back_word, res_word;
  logic      accept;
  logic      mid_empty, mid_pop;
  logic      res_full, res_push;

  // a byte is taken whenever it is pushed and the front queue has room
  assign accept = push_i && !full_o;

  socu_front #(
    .PatternMax (PATTERN_MAX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .start_i     (start_of_text_i),
    .word_o      (front_word)
  );

  // classified bytes waiting for the counter
  socu_fifo #(
    .Width ($bits(mid_word_t))
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (front_word),
    .full_o  (full_o),
    .pop_i   (mid_pop),
    .data_o  (mid_word),
    .empty_o (mid_empty)
  );

  socu_back #(
    .CountBits (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_word_i  (mid_word),
    .mid_pop_o   (mid_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_word_o  (back_word)
  );

  // finished results waiting for the consumer
  socu_fifo #(
    .Width ($bits(res_word_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_word),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_word),
    .empty_o (empty_o)
  );

  assign match_ends_here_o  = res_word.match;
  assign occurrence_count_o = res_word.count;
  assign count_saturated_o  = res_word.sat;

endmodule

// ===== verif/tb_substring_occurrence_counter_unit.sv =====
// testbench for substring_occurrence_counter_unit: directed and random text words with
// pattern changes between phases, every result checked against a local predictor
// depends on socu_pkg and substring_occurrence_counter_unit
`timescale 1ns / 1ps

module tb_substring_occurrence_counter_unit;
  import socu_pkg::*;

  localparam int unsigned HistDepth  = PatBytes - 1;
  localparam int unsigned CountMax   = 65535;
  // about 650 words plus config and drain gaps; the limit is far above what they need
  localparam int unsigned CycleLimit = 60_000;
  localparam int unsigned HoldCycles = 90;
  localparam int unsigned IdlePct    = 18;
  localparam int unsigned PhaseWords = 42;
  localparam int unsigned RunWords   = 24;

  typedef struct packed {
    logic [ByteW-1:0] text;
    logic             sot;
  } text_word_t;

  // dut ports
  logic                 clk_i              = 1'b0;
  logic                 rst_ni             = 1'b0;
  logic                 cfg_we_i           = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i          = CfgPatternLow;
  logic [CfgDataW-1:0]  cfg_data_i         = '0;
  logic                 push_i             = 1'b0;
  logic                 full_o;
  logic [ByteW-1:0]     text_byte_i        = '0;
  logic                 start_of_text_i    = 1'b0;
  logic                 pop_i              = 1'b0;
  logic                 empty_o;
  logic                 match_ends_here_o;
  logic [OutCountW-1:0] occurrence_count_o;
  logic                 count_saturated_o;

  // shadow of the pattern registers and of the scan state
  logic [CfgDataW-1:0]  pat_lo_q  = '0;
  logic [CfgDataW-1:0]  pat_hi_q  = '0;
  logic [LenW-1:0]      pat_len_q = '0;
  logic [ByteW-1:0]     recent_text [HistDepth];
  int unsigned          hist_fill = 0;
  int unsigned          hit_count = 0;

  text_word_t           pending_text [$];
  res_word_t            expected_res [$];
  text_word_t           next_word;
  text_word_t           taken_word;
  res_word_t            want;
  logic                 offering     = 1'b0;

  int unsigned          cycle_cnt    = 0;
  int unsigned          hold_left    = 0;
  int unsigned          holds_done   = 0;
  int unsigned          next_hold_at = 0;
  int unsigned          mismatch_cnt = 0;
  int unsigned          result_idx   = 0;

  substring_occurrence_counter_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .push_i             (push_i),
    .full_o             (full_o),
    .text_byte_i        (text_byte_i),
    .start_of_text_i    (start_of_text_i),
    .pop_i              (pop_i),
    .empty_o            (empty_o),
    .match_ends_here_o  (match_ends_here_o),
    .occurrence_count_o (occurrence_count_o),
    .count_saturated_o  (count_saturated_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatch_cnt < 100) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatch_cnt++;
  endtask

  // random idle decision, switched off in the late part of each period of the cycle count
  function automatic logic take_break();
    return ((cycle_cnt % 1000) < 700) && ($urandom_range(99) < IdlePct);
  endfunction

  function automatic logic [ByteW-1:0] pattern_at(input int unsigned k);
    logic [2*CfgDataW-1:0] both;
    both = {pat_hi_q, pat_lo_q};
    return both[8*(k % PatBytes) +: 8];
  endfunction

  function automatic int unsigned used_len();
    return (pat_len_q > PatBytes) ? PatBytes : int'(pat_len_q);
  endfunction

  function automatic void clear_history();
    foreach (recent_text[k]) recent_text[k] = '0;
    hist_fill = 0;
    hit_count = 0;
  endfunction

  // one accepted text word -> one expected result word
  function automatic void predict_count(input text_word_t w);
    int unsigned len;
    logic        hit;
    res_word_t   r;
    if (w.sot) begin
      clear_history();
    end
    len = used_len();
    hit = 1'b0;
    // the newest byte is compared with the last pattern byte, history with the rest
    if (len > 0 && hist_fill >= len - 1) begin
      hit = (pattern_at(len - 1) == w.text);
      for (int unsigned k = 1; k < len; k++) begin
        if (pattern_at(len - 1 - k) != recent_text[k - 1]) hit = 1'b0;
      end
    end
    if (hit && hit_count < CountMax) hit_count++;
    for (int k = HistDepth - 1; k > 0; k--) recent_text[k] = recent_text[k - 1];
    recent_text[0] = w.text;
    if (hist_fill < HistDepth) hist_fill++;
    r.match = hit;
    r.count = hit_count[OutCountW-1:0];
    r.sat   = (hit_count == CountMax);
    expected_res.push_back(r);
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgPatternLow:  pat_lo_q = data;
      CfgPatternHigh: pat_hi_q = data;
      CfgPatternLen:  pat_len_q = data[LenW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_pattern(input logic [CfgDataW-1:0] lo, input logic [CfgDataW-1:0] hi,
                              input logic [LenW-1:0] len);
    write_reg(CfgPatternLow, lo);
    write_reg(CfgPatternHigh, hi);
    write_reg(CfgPatternLen, CfgDataW'(len));
  endtask

  task automatic queue_word(input logic [ByteW-1:0] text, input logic sot);
    text_word_t w;
    w.text = text;
    w.sot  = sot;
    pending_text.push_back(w);
  endtask

  // waits until every word is taken and every result has come back
  task automatic wait_drained();
    while (pending_text.size() != 0 || offering || expected_res.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // two-letter alphabet most of the time so that overlapping hits are common
  task automatic load_random_pattern(input logic [LenW-1:0] len);
    logic [2*CfgDataW-1:0] bytes;
    logic [ByteW-1:0]      a;
    logic [ByteW-1:0]      b;
    a = ByteW'($urandom);
    b = ByteW'($urandom);
    for (int k = 0; k < PatBytes; k++) begin
      bytes[8*k +: 8] = ($urandom_range(1) == 0) ? a : b;
    end
    if ($urandom_range(2) == 0) begin
      bytes = {$urandom, $urandom, $urandom, $urandom};
    end
    load_pattern(bytes[CfgDataW-1:0], bytes[2*CfgDataW-1:CfgDataW], len);
  endtask

  // mostly whole pattern copies, some cut-off copies and some noise bytes
  task automatic queue_random_text(input int unsigned n_words);
    int unsigned len;
    int unsigned pick;
    int unsigned part;
    int unsigned sent;
    len  = used_len();
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(99);
      if (len > 0 && pick < 60) begin
        for (int unsigned k = 0; k < len; k++) begin
          queue_word(pattern_at(k), $urandom_range(99) < 2);
        end
        sent += len;
      end else if (len > 1 && pick < 75) begin
        part = $urandom_range(len - 1, 1);
        for (int unsigned k = 0; k < part; k++) begin
          queue_word(pattern_at(k), $urandom_range(99) < 2);
        end
        sent += part;
      end else begin
        if ($urandom_range(1) == 0) begin
          queue_word(pattern_at($urandom_range(PatBytes - 1)), $urandom_range(99) < 3);
        end else begin
          queue_word(ByteW'($urandom), $urandom_range(99) < 3);
        end
        sent++;
      end
    end
  endtask

  // sender: holds a word until taken, then maybe idles before the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_o) begin
        taken_word.text = text_byte_i;
        taken_word.sot  = start_of_text_i;
        predict_count(taken_word);
        offering = 1'b0;
      end
      if (!offering) begin
        if (pending_text.size() != 0 && !take_break()) begin
          next_word = pending_text.pop_front();
          text_byte_i     <= next_word.text;
          start_of_text_i <= next_word.sot;
          push_i          <= 1'b1;
          offering = 1'b1;
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each popped word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_res.size() == 0) begin
        flag_mismatch($sformatf("result %0d not expected: match=%0b count=%0d sat=%0b",
                                result_idx, match_ends_here_o, occurrence_count_o,
                                count_saturated_o));
      end else begin
        want = expected_res.pop_front();
        if (match_ends_here_o !== want.match) begin
          flag_mismatch($sformatf("result %0d match_ends_here %0b, want %0b",
                                  result_idx, match_ends_here_o, want.match));
        end
        if (occurrence_count_o !== want.count) begin
          flag_mismatch($sformatf("result %0d occurrence_count %0d, want %0d",
                                  result_idx, occurrence_count_o, want.count));
        end
        if (count_saturated_o !== want.sat) begin
          flag_mismatch($sformatf("result %0d count_saturated %0b, want %0b",
                                  result_idx, count_saturated_o, want.sat));
        end
      end
      result_idx++;
    end
    pop_i <= (hold_left == 0) && !take_break();
  end

  // cycle count and long receiver hold-offs while plenty of words wait to go in
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (rst_ni && holds_done < 3 && cycle_cnt >= next_hold_at &&
                 pending_text.size() > 40) begin
      hold_left    <= HoldCycles;
      holds_done   <= holds_done + 1;
      next_hold_at <= cycle_cnt + 5000;
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned      phase_len [12];
    logic [ByteW-1:0] run_byte;
    phase_len = '{1, 16, 0, 31, 2, 3, 17, 8, 15, 16, 0, 0};
    phase_len[10] = $urandom_range(PatBytes, 1);
    phase_len[11] = $urandom_range(PatBytes, 1);
    clear_history();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers at their reset values: length zero, zero bytes never match
    queue_word(8'h00, 1'b1);
    queue_word(8'hFF, 1'b0);
    queue_word(8'h00, 1'b0);
    wait_drained();

    // full length pattern with zero and all-ones bytes, hit only once history is full
    load_pattern(64'h0123_4567_89AB_CD00, 64'hFF00_5A3C_C3A5_11EE, LenW'(PatBytes));
    for (int unsigned k = 0; k < PatBytes; k++) begin
      queue_word(pattern_at(k), k == 0);
    end
    queue_word(pattern_at(PatBytes - 1), 1'b0);
    wait_drained();

    // two zero bytes over a run of zeros: overlapping hits
    load_pattern('0, 64'hFFFF_FFFF_FFFF_FFFF, LenW'(2));
    queue_word(8'h00, 1'b1);
    repeat (3) queue_word(8'h00, 1'b0);
    wait_drained();

    foreach (phase_len[p]) begin
      load_random_pattern(LenW'(phase_len[p]));
      queue_random_text(PhaseWords);
      wait_drained();
    end

    // one-byte pattern over a run of the same byte, a miss, then a restart
    load_random_pattern(LenW'(1));
    run_byte = pattern_at(0);
    queue_word(run_byte, 1'b1);
    repeat (RunWords) queue_word(run_byte, 1'b0);
    queue_word(~run_byte, 1'b0);
    queue_word(run_byte, 1'b0);
    queue_word(run_byte, 1'b1);
    queue_word(run_byte, 1'b0);
    wait_drained();

    load_random_pattern(LenW'(PatBytes));
    queue_random_text(PhaseWords);
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== substring_occurrence_counter_unit.f =====
+incdir+hw/rtl
hw/rtl/socu_pkg.sv
hw/rtl/socu_fifo.sv
hw/rtl/socu_front.sv
hw/rtl/socu_back.sv
hw/rtl/substring_occurrence_counter_unit.sv
verif/tb_substring_occurrence_counter_unit.sv
